@@ rtl/core/ptd_pkg.sv @@
// Shared constants and control types for the periodic task dispatcher.
`timescale 1ns / 1ps

package ptd_pkg;

    localparam int MAX_TASKS_DEF = 8;
    localparam int TICK_W        = 32;
    localparam int DELAY_W       = 16;
    localparam int ACTION_W      = 2;
    localparam int INDEX_W       = 6;

    localparam logic [ACTION_W-1:0] ACT_INIT     = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_START    = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_DISPATCH = 2'd2;

    localparam logic [TICK_W-1:0] IDLE_NONE = 32'hFFFF_FFFF;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;   // an item transfer happens this cycle
        logic walk;     // table walk in progress
        logic finish;   // last entry is processed this cycle
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic table_empty;
        logic last_entry;
    } t_status;

endpackage

@@ rtl/core/ptd_ctrl.sv @@
// Controller state machine: accepts items and sequences the table walk.
`timescale 1ns / 1ps

module ptd_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    input  logic [ptd_pkg::ACTION_W-1:0]  i_action,
    input  ptd_pkg::t_status              i_status,
    output ptd_pkg::t_cmd                 o_cmd,
    output logic                          busy,
    output logic                          strobe
);
    import ptd_pkg::*;

    localparam logic [0:0] ST_IDLE = 1'b0;
    localparam logic [0:0] ST_WALK = 1'b1;

    logic [0:0] r_state, n_state;
    logic       r_strobe, n_strobe;
    logic       accept;
    logic       go_walk;

    assign accept  = start && (r_state == ST_IDLE);
    assign go_walk = accept && (i_action == ACT_DISPATCH) && !i_status.table_empty;

    always_comb begin
        n_state  = r_state;
        n_strobe = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (go_walk) begin
                    n_state = ST_WALK;
                end else if (accept) begin
                    n_strobe = 1'b1;
                end
            end
            ST_WALK: begin
                if (i_status.last_entry) begin
                    n_state  = ST_IDLE;
                    n_strobe = 1'b1;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
    end

    assign o_cmd.accept = accept;
    assign o_cmd.walk   = (r_state == ST_WALK);
    assign o_cmd.finish = (r_state == ST_WALK) && i_status.last_entry;
    assign busy         = (r_state != ST_IDLE);
    assign strobe       = r_strobe;

endmodule

@@ rtl/core/ptd_dpath.sv @@
// Datapath: task table memory, time base, walk pipeline and result registers.
`timescale 1ns / 1ps

module ptd_dpath #(
    parameter int MAX_TASKS = ptd_pkg::MAX_TASKS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  ptd_pkg::t_cmd                       i_cmd,
    input  logic [ptd_pkg::ACTION_W-1:0]        i_action,
    input  logic [ptd_pkg::TICK_W-1:0]          i_now_ticks,
    input  logic signed [ptd_pkg::DELAY_W-1:0]  i_start_delay,
    input  logic signed [ptd_pkg::DELAY_W-1:0]  i_task_period,
    output ptd_pkg::t_status                    o_status,
    output logic                                o_task_valid,
    output logic [ptd_pkg::INDEX_W-1:0]         o_task_index,
    output logic [ptd_pkg::TICK_W-1:0]          o_idle_ticks
);
    import ptd_pkg::*;

    localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CW = $clog2(MAX_TASKS + 1);

    logic [TICK_W-1:0]  r_rem_mem [MAX_TASKS];
    logic [DELAY_W-1:0] r_per_mem [MAX_TASKS];

    logic [CW-1:0]      r_count;
    logic [TICK_W-1:0]  r_last;
    logic [TICK_W-1:0]  r_elapsed;
    logic [TICK_W-1:0]  r_best;
    logic               r_found;
    logic [CW-1:0]      r_sel;
    logic [CW-1:0]      r_rd_idx;
    logic [CW-1:0]      r_rd_at;
    logic               r_rd_vld;
    logic [TICK_W-1:0]  r_rd_rem;
    logic [DELAY_W-1:0] r_rd_per;

    logic               table_full;
    logic               start_ok;
    logic               rd_more;
    logic               wr_en;
    logic [IW-1:0]      wr_addr;
    logic [TICK_W-1:0]  wr_rem;
    logic [TICK_W-1:0]  diff;
    logic               due;
    logic               take;
    logic [TICK_W-1:0]  upd_rem;
    logic [TICK_W-1:0]  nxt_best;
    logic               nxt_found;
    logic [CW-1:0]      nxt_sel;

    assign table_full = (r_count >= CW'(MAX_TASKS));
    assign start_ok   = i_cmd.accept && (i_action == ACT_START) && !table_full;
    assign rd_more    = i_cmd.walk && (r_rd_idx < r_count);

    // Evaluate the entry that came out of the memory last cycle.
    always_comb begin
        diff      = r_rd_rem - r_elapsed;
        due       = (diff == '0) || diff[TICK_W-1];
        take      = due && !r_found;
        upd_rem   = take ? diff + {{(TICK_W-DELAY_W){r_rd_per[DELAY_W-1]}}, r_rd_per} : diff;
        nxt_found = r_found || due;
        nxt_sel   = r_found ? r_sel : r_rd_at;
        if (due) begin
            nxt_best = '0;
        end else if (diff < r_best) begin
            nxt_best = diff;
        end else begin
            nxt_best = r_best;
        end
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_rd_at[IW-1:0];
        wr_rem  = upd_rem;
        if (start_ok) begin
            wr_en   = 1'b1;
            wr_addr = r_count[IW-1:0];
            wr_rem  = {{(TICK_W-DELAY_W){i_start_delay[DELAY_W-1]}}, i_start_delay};
        end else if (r_rd_vld) begin
            wr_en = 1'b1;
        end
    end

    // Table memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_rem_mem[wr_addr] <= wr_rem;
        end
        if (start_ok) begin
            r_per_mem[wr_addr] <= i_task_period;
        end
        if (rd_more) begin
            r_rd_rem <= r_rem_mem[r_rd_idx[IW-1:0]];
            r_rd_per <= r_per_mem[r_rd_idx[IW-1:0]];
            r_rd_at  <= r_rd_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_last   <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= rd_more;
            if (i_cmd.accept) begin
                case (i_action)
                    ACT_INIT:     r_last <= i_now_ticks;
                    ACT_START:    if (!table_full) r_count <= r_count + 1'b1;
                    ACT_DISPATCH: r_last <= i_now_ticks;
                    default:      r_last <= r_last;
                endcase
            end
        end
    end

    // Walk state and result fields.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            o_task_valid <= start_ok;
            o_task_index <= start_ok ? INDEX_W'(r_count) : '0;
            o_idle_ticks <= (i_action == ACT_DISPATCH) ? IDLE_NONE : '0;
            if (i_action == ACT_DISPATCH) begin
                r_elapsed <= i_now_ticks - r_last;
                r_best    <= IDLE_NONE;
                r_found   <= 1'b0;
                r_sel     <= '0;
                r_rd_idx  <= '0;
            end
        end else begin
            if (rd_more) begin
                r_rd_idx <= r_rd_idx + 1'b1;
            end
            if (r_rd_vld) begin
                r_best  <= nxt_best;
                r_found <= nxt_found;
                r_sel   <= nxt_sel;
            end
            if (i_cmd.finish) begin
                o_task_valid <= nxt_found;
                o_task_index <= nxt_found ? INDEX_W'(nxt_sel) : '0;
                o_idle_ticks <= nxt_best;
            end
        end
    end

    assign o_status.table_empty = (r_count == '0);
    assign o_status.last_entry  = r_rd_vld && (r_rd_at == r_count - 1'b1);

endmodule

@@ rtl/core/periodic_task_dispatcher.sv @@
// Top level of the periodic task dispatcher: controller plus datapath.
//
//  channel  | signals                                          | handshake
//  ---------+--------------------------------------------------+------------------------
//  command  | i_action i_now_ticks i_start_delay i_task_period | start & !busy
//  result   | o_task_valid o_task_index o_idle_ticks           | strobe, one cycle, no stall
//
// Init, start task, unused codes and dispatch on an empty table: the result shows
// in the cycle after the transfer; a new command can be taken in every cycle.
// Dispatch walks the table through the single memory read port, one entry a cycle:
// busy stays high while the table is walked, the result strobes right after.
// Reset (synchronous, active low) empties the table and clears the time base.
// The receiver cannot stall; each result is shown once.
`timescale 1ns / 1ps

module periodic_task_dispatcher #(
    parameter int MAX_TASKS = ptd_pkg::MAX_TASKS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [ptd_pkg::ACTION_W-1:0]        i_action,
    input  logic [ptd_pkg::TICK_W-1:0]          i_now_ticks,
    input  logic signed [ptd_pkg::DELAY_W-1:0]  i_start_delay,
    input  logic signed [ptd_pkg::DELAY_W-1:0]  i_task_period,
    output logic                                strobe,
    output logic                                o_task_valid,
    output logic [ptd_pkg::INDEX_W-1:0]         o_task_index,
    output logic [ptd_pkg::TICK_W-1:0]          o_idle_ticks
);
    import ptd_pkg::*;

    t_cmd    cmd;
    t_status status;

    ptd_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_action (i_action),
        .i_status (status),
        .o_cmd    (cmd),
        .busy     (busy),
        .strobe   (strobe)
    );

    ptd_dpath #(
        .MAX_TASKS (MAX_TASKS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_action      (i_action),
        .i_now_ticks   (i_now_ticks),
        .i_start_delay (i_start_delay),
        .i_task_period (i_task_period),
        .o_status      (status),
        .o_task_valid  (o_task_valid),
        .o_task_index  (o_task_index),
        .o_idle_ticks  (o_idle_ticks)
    );

endmodule

@@ rtl/core/ptd_checker.sv @@
// Port-level checks for the periodic task dispatcher, bound to the top level.
`timescale 1ns / 1ps

module ptd_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                start,
    input logic                                busy,
    input logic [ptd_pkg::ACTION_W-1:0]        i_action,
    input logic                                strobe,
    input logic                                o_task_valid,
    input logic [ptd_pkg::INDEX_W-1:0]         o_task_index,
    input logic [ptd_pkg::TICK_W-1:0]          o_idle_ticks
);
    import ptd_pkg::*;

    // Anything but dispatch answers in the next cycle.
    a_quick_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_action != ACT_DISPATCH)) |=> strobe)
        else $error("non-dispatch transfer without result next cycle");

    // Dispatch either answers at once or keeps the block busy.
    a_dispatch_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_action == ACT_DISPATCH)) |=> (strobe || busy))
        else $error("dispatch transfer dropped");

    // A result only follows a transfer or the end of a walk.
    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        strobe |-> ($past(start && !busy) || $past(busy)))
        else $error("result without a command");

    // A selected or accepted task always reports zero idle time.
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (strobe && o_task_valid) |-> (o_idle_ticks == '0))
        else $error("task selected with nonzero idle time");

    // No active task means nothing selected.
    a_none_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (strobe && (o_idle_ticks == IDLE_NONE)) |-> (!o_task_valid && (o_task_index == '0)))
        else $error("empty idle time with a selected task");

endmodule

bind periodic_task_dispatcher ptd_checker u_ptd_checker (.*);
